### src/assert_macros.svh
// Assertion macros shared by the RTL of the polar Gaussian generator.
// Needs no other file; the macros expand to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define PGG_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PGG_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PGG_ASSERT(label, clk, rstn, prop, msg)
`define PGG_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

### src/pgg_pkg.sv
// Shared constants and pipeline payload types of the polar Gaussian generator.
// Used by the cell modules and the top level; depends on nothing.
package pgg_pkg;

    localparam int UNIFORM_BITS_DEF  = 32;
    localparam int CORDIC_STAGES_DEF = 32;
    localparam int F_BITS            = 48;
    localparam int DIV_STEPS         = 33;
    localparam int SQRT_STEPS        = 31;
    localparam int CFG_IDX_W         = 4;

    localparam logic [31:0] LN2_HI = 32'hB17217F7;
    localparam logic [31:0] LN2_LO = 32'hD1CF79AB;

    localparam logic [CFG_IDX_W-1:0] REG_MEAN    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STD_DEV = 4'd1;

    typedef struct packed {
        logic        v1_neg;
        logic [31:0] v1_mag;
        logic        v2_neg;
        logic [31:0] v2_mag;
    } pair_t;

    typedef struct packed {
        pair_t              pair;
        logic [5:0]         e;
        logic [31:0]        x0;
        logic [31:0]        x;
        logic [F_BITS-1:0]  f;
    } log_t;

    typedef struct packed {
        pair_t              pair;
        logic [5:0]         e;
        logic [F_BITS-1:0]  f;
        logic [31:0]        x0;
        logic [31:0]        rem;
        logic [DIV_STEPS-1:0] quo;
    } dv_t;

    typedef struct packed {
        pair_t                 pair;
        logic [4:0]            h;
        logic [61:0]           rem;
        logic [SQRT_STEPS-1:0] res;
    } sq_t;

endpackage

### src/pgg_log_cell.sv
// One squaring step of the base-2 logarithm chain; yields one fraction bit.
// Depends on pgg_pkg.
module pgg_log_cell #(
    parameter int STEP = 0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  logic          in_valid,
    input  pgg_pkg::log_t in_data,
    output logic          out_valid,
    output pgg_pkg::log_t out_data
);

    logic [63:0]   sq;
    logic [32:0]   y;
    pgg_pkg::log_t data_next;
    pgg_pkg::log_t data_reg;
    logic          valid_reg;

    always_comb begin
        sq = in_data.x * in_data.x;
        y = sq[63:31];
        data_next = in_data;
        if (y[32]) begin
            data_next.x = y[32:1];
            data_next.f[pgg_pkg::F_BITS-1-STEP] = 1'b1;
        end else begin
            data_next.x = y[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### src/pgg_div_cell.sv
// One restoring step of the reciprocal divider; yields one quotient bit.
// Depends on pgg_pkg.
module pgg_div_cell (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         adv,
    input  logic         in_valid,
    input  pgg_pkg::dv_t in_data,
    output logic         out_valid,
    output pgg_pkg::dv_t out_data
);

    logic [32:0]  trial;
    logic [32:0]  diff;
    logic         take;
    pgg_pkg::dv_t data_next;
    pgg_pkg::dv_t data_reg;
    logic         valid_reg;

    always_comb begin
        trial = {in_data.rem, 1'b1};
        diff = trial - {1'b0, in_data.x0};
        take = (trial >= {1'b0, in_data.x0});
        data_next = in_data;
        data_next.rem = take ? diff[31:0] : trial[31:0];
        data_next.quo = {in_data.quo[pgg_pkg::DIV_STEPS-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### src/pgg_sqrt_cell.sv
// One step of the digit-by-digit square root; settles one result bit.
// Depends on pgg_pkg.
module pgg_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         adv,
    input  logic         in_valid,
    input  pgg_pkg::sq_t in_data,
    output logic         out_valid,
    output pgg_pkg::sq_t out_data
);

    logic [63:0]  trial;
    logic         take;
    pgg_pkg::sq_t data_next;
    pgg_pkg::sq_t data_reg;
    logic         valid_reg;

    always_comb begin
        trial = ({{(64-pgg_pkg::SQRT_STEPS){1'b0}}, in_data.res} << (BIT + 1))
              + (64'd1 << (2 * BIT));
        take = ({2'b0, in_data.rem} >= trial);
        data_next = in_data;
        if (take) begin
            data_next.rem = in_data.rem - trial[61:0];
            data_next.res[BIT] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### src/polar_gaussian_generator_unit.sv
// Polar-method Gaussian generator: one uniform pair in, two Q16.16 samples out.
// The first sample passes the front end, the logarithm, divider and square-root cell
// chains and the sample lanes; the second follows.
// The pipeline takes a new pair only while the two-sample output register is empty
// or its second sample is taken; rejected pairs leave no sample. Synchronous
// active-low reset empties the pipeline and sets mean to 0 and std_dev to 1.0.
module polar_gaussian_generator_unit #(
    parameter int UNIFORM_BITS  = pgg_pkg::UNIFORM_BITS_DEF,
    parameter int CORDIC_STAGES = pgg_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [pgg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [31:0]                   s_uniform_a,
    input  logic [31:0]                   s_uniform_b,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [31:0]            m_sample,
    output logic                          m_last_of_pair
);

    `include "assert_macros.svh"

    localparam int DROP = (UNIFORM_BITS < 32) ? (32 - UNIFORM_BITS) : 0;
    localparam logic [31:0] U_MASK = 32'hFFFFFFFF << DROP;
    localparam logic signed [42:0] SAT_MAX = 43'sd2147483647;
    localparam logic signed [42:0] SAT_MIN = -43'sd2147483648;
    localparam logic [40:0] MAG_CAP = 41'h100_0000_0000;

    function automatic logic [32:0] to_signed_mag(input logic [31:0] u);
        logic [31:0] um;
        logic [31:0] mag;
        um = u & U_MASK;
        mag = um[31] ? {1'b0, um[30:0]} : (32'h8000_0000 - um);
        return {!um[31], mag};
    endfunction

    function automatic logic [63:0] scale_z(input logic [62:0] z, input logic [4:0] h);
        logic [66:0] wide;
        logic [63:0] res;
        wide = {4'b0, z} << (h - 5'd26);
        if (h <= 5'd26) begin
            res = {1'b0, z} >> (5'd26 - h);
        end else if (wide[66:64] != 3'b0) begin
            res = '1;
        end else begin
            res = wide[63:0];
        end
        return res;
    endfunction

    function automatic logic [31:0] finish(input logic neg, input logic [40:0] mag,
                                           input logic signed [31:0] mean);
        logic signed [42:0] total;
        total = neg ? -$signed({2'b0, mag}) : $signed({2'b0, mag});
        total = total + 43'(mean);
        if (total > SAT_MAX) begin
            total = SAT_MAX;
        end else if (total < SAT_MIN) begin
            total = SAT_MIN;
        end
        return total[31:0];
    endfunction

    logic signed [31:0] mean_reg;
    logic signed [31:0] std_dev_reg;
    logic               adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mean_reg    <= 32'sd0;
            std_dev_reg <= 32'sd65536;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pgg_pkg::REG_MEAN:    mean_reg    <= cfg_wdata;
                pgg_pkg::REG_STD_DEV: std_dev_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Front end: centring, squares, sum and range check, normalisation.
    logic [32:0]     in_a;
    logic [32:0]     in_b;
    logic            s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    pgg_pkg::pair_t  s1_pair_reg, s2_pair_reg, s3_pair_reg, s4_pair_reg;
    logic [63:0]     sq1_reg, sq2_reg;
    logic [63:0]     s3_sum;
    logic [63:0]     s3_reg;
    logic [63:0]     t4_next, t4_reg;
    logic [5:0]      lz4_next, lz4_reg;
    logic [63:0]     t5_next;
    logic [5:0]      lz5_next;
    pgg_pkg::log_t   s5_data_reg;

    assign in_a   = to_signed_mag(s_uniform_a);
    assign in_b   = to_signed_mag(s_uniform_b);
    assign s3_sum = sq1_reg + sq2_reg;

    always_comb begin
        t4_next = s3_reg;
        lz4_next = 6'd0;
        if (t4_next[63:32] == 32'b0) begin
            t4_next = t4_next << 32;
            lz4_next = lz4_next + 6'd32;
        end
        if (t4_next[63:48] == 16'b0) begin
            t4_next = t4_next << 16;
            lz4_next = lz4_next + 6'd16;
        end
        if (t4_next[63:56] == 8'b0) begin
            t4_next = t4_next << 8;
            lz4_next = lz4_next + 6'd8;
        end
        t5_next = t4_reg;
        lz5_next = lz4_reg;
        if (t5_next[63:60] == 4'b0) begin
            t5_next = t5_next << 4;
            lz5_next = lz5_next + 6'd4;
        end
        if (t5_next[63:62] == 2'b0) begin
            t5_next = t5_next << 2;
            lz5_next = lz5_next + 6'd2;
        end
        if (!t5_next[63]) begin
            t5_next = t5_next << 1;
            lz5_next = lz5_next + 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg <= s_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg && (s3_sum != 64'b0) && (s3_sum[63:62] == 2'b0);
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_pair_reg       <= {in_a[32], in_a[31:0], in_b[32], in_b[31:0]};
            sq1_reg           <= s1_pair_reg.v1_mag * s1_pair_reg.v1_mag;
            sq2_reg           <= s1_pair_reg.v2_mag * s1_pair_reg.v2_mag;
            s2_pair_reg       <= s1_pair_reg;
            s3_reg            <= s3_sum;
            s3_pair_reg       <= s2_pair_reg;
            t4_reg            <= t4_next;
            lz4_reg           <= lz4_next;
            s4_pair_reg       <= s3_pair_reg;
            s5_data_reg.pair  <= s4_pair_reg;
            s5_data_reg.e     <= lz5_next - 6'd1;
            s5_data_reg.x0    <= t5_next[63:32];
            s5_data_reg.x     <= t5_next[63:32];
            s5_data_reg.f     <= '0;
        end
    end

    // Logarithm chain.
    logic          log_valid [0:CORDIC_STAGES];
    pgg_pkg::log_t log_data  [0:CORDIC_STAGES];

    assign log_valid[0] = s5_valid_reg;
    assign log_data[0]  = s5_data_reg;

    for (genvar j = 0; j < CORDIC_STAGES; j++) begin : g_log
        pgg_log_cell #(.STEP(j)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (log_valid[j]),
            .in_data   (log_data[j]),
            .out_valid (log_valid[j+1]),
            .out_data  (log_data[j+1])
        );
    end

    // Reciprocal chain: floor((2^64 - 1) / x).
    logic         div_valid [0:pgg_pkg::DIV_STEPS];
    pgg_pkg::dv_t div_data  [0:pgg_pkg::DIV_STEPS];

    assign div_valid[0]     = log_valid[CORDIC_STAGES];
    assign div_data[0].pair = log_data[CORDIC_STAGES].pair;
    assign div_data[0].e    = log_data[CORDIC_STAGES].e;
    assign div_data[0].f    = log_data[CORDIC_STAGES].f;
    assign div_data[0].x0   = log_data[CORDIC_STAGES].x0;
    assign div_data[0].rem  = 32'h7FFF_FFFF;
    assign div_data[0].quo  = '0;

    for (genvar j = 0; j < pgg_pkg::DIV_STEPS; j++) begin : g_div
        pgg_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (div_valid[j]),
            .in_data   (div_data[j]),
            .out_valid (div_valid[j+1]),
            .out_data  (div_data[j+1])
        );
    end

    // Natural logarithm scaling and the product that feeds the square root.
    pgg_pkg::dv_t   dv_out;
    logic           l1_valid_reg, l2_valid_reg, l3_valid_reg, l4_valid_reg, l5_valid_reg;
    pgg_pkg::pair_t l1_pair_reg, l2_pair_reg, l3_pair_reg, l4_pair_reg;
    logic [53:0]    nl_reg;
    logic [5:0]     l1_e_reg, l2_e_reg;
    logic [32:0]    l1_r_reg, l2_r_reg, l3_r_reg;
    logic [53:0]    pa_reg, pb_reg;
    logic [63:0]    pc_reg, pd_reg;
    logic [127:0]   l3_full;
    logic [53:0]    l3_hi;
    logic [55:0]    w_reg;
    logic [4:0]     l3_h_reg, l4_h_reg;
    logic [60:0]    wa_reg, wb_reg;
    logic [88:0]    l5_prod;
    pgg_pkg::sq_t   l5_data_reg;

    assign dv_out = div_data[pgg_pkg::DIV_STEPS];

    assign l3_full = ({74'b0, pa_reg} << 64) + ({74'b0, pb_reg} << 32)
                   + ({64'b0, pc_reg} << 32) + {64'b0, pd_reg};
    assign l3_hi   = l3_full[117:64];
    assign l5_prod = {wa_reg, 28'b0} + {28'b0, wb_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1_valid_reg <= 1'b0;
            l2_valid_reg <= 1'b0;
            l3_valid_reg <= 1'b0;
            l4_valid_reg <= 1'b0;
            l5_valid_reg <= 1'b0;
        end else if (adv) begin
            l1_valid_reg <= div_valid[pgg_pkg::DIV_STEPS];
            l2_valid_reg <= l1_valid_reg;
            l3_valid_reg <= l2_valid_reg;
            l4_valid_reg <= l3_valid_reg;
            l5_valid_reg <= l4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nl_reg      <= {dv_out.e, 48'b0} - {6'b0, dv_out.f};
            l1_e_reg    <= dv_out.e;
            l1_r_reg    <= dv_out.quo;
            l1_pair_reg <= dv_out.pair;
            pa_reg      <= nl_reg[53:32] * pgg_pkg::LN2_HI;
            pb_reg      <= nl_reg[53:32] * pgg_pkg::LN2_LO;
            pc_reg      <= nl_reg[31:0] * pgg_pkg::LN2_HI;
            pd_reg      <= nl_reg[31:0] * pgg_pkg::LN2_LO;
            l2_e_reg    <= l1_e_reg;
            l2_r_reg    <= l1_r_reg;
            l2_pair_reg <= l1_pair_reg;
            w_reg       <= l2_e_reg[0] ? {l3_hi, 2'b0} : {1'b0, l3_hi, 1'b0};
            l3_h_reg    <= l2_e_reg[5:1];
            l3_r_reg    <= l2_r_reg;
            l3_pair_reg <= l2_pair_reg;
            wa_reg      <= w_reg[55:28] * l3_r_reg;
            wb_reg      <= w_reg[27:0] * l3_r_reg;
            l4_h_reg    <= l3_h_reg;
            l4_pair_reg <= l3_pair_reg;
            l5_data_reg.pair <= l4_pair_reg;
            l5_data_reg.h    <= l4_h_reg;
            l5_data_reg.rem  <= l5_prod[88:27];
            l5_data_reg.res  <= '0;
        end
    end

    // Square-root chain, most significant bit first.
    logic         sq_valid [0:pgg_pkg::SQRT_STEPS];
    pgg_pkg::sq_t sq_data  [0:pgg_pkg::SQRT_STEPS];

    assign sq_valid[0] = l5_valid_reg;
    assign sq_data[0]  = l5_data_reg;

    for (genvar j = 0; j < pgg_pkg::SQRT_STEPS; j++) begin : g_sqrt
        pgg_sqrt_cell #(.BIT(pgg_pkg::SQRT_STEPS - 1 - j)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (sq_valid[j]),
            .in_data   (sq_data[j]),
            .out_valid (sq_valid[j+1]),
            .out_data  (sq_data[j+1])
        );
    end

    // Sample lanes: scale by m, by std_dev, then offset by mean.
    pgg_pkg::sq_t sq_out;
    logic         z1_valid_reg, z2_valid_reg, z3_valid_reg, z4_valid_reg;
    logic [62:0]  za1_reg, zb1_reg;
    logic [4:0]   z1_h_reg;
    logic         na1_reg, nb1_reg, na2_reg, nb2_reg, na3_reg, nb3_reg, na4_reg, nb4_reg;
    logic [63:0]  za2_reg, zb2_reg;
    logic [31:0]  sd_mag;
    logic [63:0]  pah_reg, pal_reg, pbh_reg, pbl_reg;
    logic [95:0]  fa, fb;
    logic [40:0]  ma_reg, mb_reg;

    assign sq_out = sq_data[pgg_pkg::SQRT_STEPS];
    assign sd_mag = std_dev_reg[31] ? (32'd0 - std_dev_reg) : std_dev_reg;
    assign fa     = {pah_reg, 32'b0} + {32'b0, pal_reg};
    assign fb     = {pbh_reg, 32'b0} + {32'b0, pbl_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            z1_valid_reg <= 1'b0;
            z2_valid_reg <= 1'b0;
            z3_valid_reg <= 1'b0;
            z4_valid_reg <= 1'b0;
        end else if (adv) begin
            z1_valid_reg <= sq_valid[pgg_pkg::SQRT_STEPS];
            z2_valid_reg <= z1_valid_reg;
            z3_valid_reg <= z2_valid_reg;
            z4_valid_reg <= z3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            za1_reg  <= sq_out.pair.v1_mag * sq_out.res;
            zb1_reg  <= sq_out.pair.v2_mag * sq_out.res;
            z1_h_reg <= sq_out.h;
            na1_reg  <= sq_out.pair.v1_neg;
            nb1_reg  <= sq_out.pair.v2_neg;
            za2_reg  <= scale_z(za1_reg, z1_h_reg);
            zb2_reg  <= scale_z(zb1_reg, z1_h_reg);
            na2_reg  <= na1_reg;
            nb2_reg  <= nb1_reg;
            pah_reg  <= za2_reg[63:32] * sd_mag;
            pal_reg  <= za2_reg[31:0] * sd_mag;
            pbh_reg  <= zb2_reg[63:32] * sd_mag;
            pbl_reg  <= zb2_reg[31:0] * sd_mag;
            na3_reg  <= na2_reg ^ std_dev_reg[31];
            nb3_reg  <= nb2_reg ^ std_dev_reg[31];
            ma_reg   <= (fa[95:32] > {23'b0, MAG_CAP}) ? MAG_CAP : fa[72:32];
            mb_reg   <= (fb[95:32] > {23'b0, MAG_CAP}) ? MAG_CAP : fb[72:32];
            na4_reg  <= na3_reg;
            nb4_reg  <= nb3_reg;
        end
    end

    // Output register holding both samples of a pair.
    logic        m_valid_reg;
    logic        phase_reg;
    logic [31:0] samp0_reg, samp1_reg;

    assign adv = !m_valid_reg || (m_ready && phase_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            phase_reg   <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= z4_valid_reg;
            phase_reg   <= 1'b0;
        end else if (m_ready) begin
            phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            samp0_reg <= finish(na4_reg, ma_reg, mean_reg);
            samp1_reg <= finish(nb4_reg, mb_reg, mean_reg);
        end
    end

    assign s_ready        = adv;
    assign m_valid        = m_valid_reg;
    assign m_sample       = phase_reg ? samp1_reg : samp0_reg;
    assign m_last_of_pair = phase_reg;

    `PGG_ASSERT(a_second_follows, aclk, aresetn, m_valid && m_ready && !m_last_of_pair |=> m_valid && m_last_of_pair, "second sample of a pair did not follow the first")
    `PGG_ASSERT(a_hold_first, aclk, aresetn, m_valid && !m_last_of_pair |-> !s_ready, "new item taken while the first sample is still pending")
    `PGG_ASSERT_RST(a_reset_empty, aclk, !aresetn |=> !m_valid, "output valid straight after reset")

endmodule

### tb/tb_polar_gaussian_generator_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for polar_gaussian_generator_unit: drives uniform pairs and
// compares every sample with a fixed-point polar-method predictor. Depends on pgg_pkg.
module tb_polar_gaussian_generator_unit;

    localparam logic [pgg_pkg::CFG_IDX_W-1:0] REG_UNUSED = 4'd9;
    localparam int DRAIN_CYCLES = pgg_pkg::CORDIC_STAGES_DEF + 100;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RAND_PER_PHASE = 80;
    localparam int NUM_PHASES = 6;

    typedef struct {
        logic signed [31:0] sample;
        logic               last;
    } gauss_out_t;

    typedef struct {
        logic [31:0] ua;
        logic [31:0] ub;
        bit          known_reject;
    } pair_row_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [pgg_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]                   cfg_wdata;
    logic                          s_valid;
    logic                          s_ready;
    logic [31:0]                   s_uniform_a;
    logic [31:0]                   s_uniform_b;
    logic                          m_valid;
    logic                          m_ready;
    logic signed [31:0]            m_sample;
    logic                          m_last_of_pair;

    gauss_out_t  pending_samples[$];
    logic signed [31:0] mean_mirror;
    logic signed [31:0] std_mirror;
    int errors;
    int pairs_sent;
    int pairs_rejected;
    int samples_seen;
    int stall_count;
    bit calm;
    bit hold_request;

    polar_gaussian_generator_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_uniform_a(s_uniform_a), .s_uniform_b(s_uniform_b),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_sample(m_sample), .m_last_of_pair(m_last_of_pair)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [63:0] isqrt64(logic [63:0] q);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > q) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (q >= res + bitv) begin
                q = q - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] scale_sample(longint v, logic [63:0] mb, int h);
        logic [63:0]  vmag;
        logic [63:0]  sdmag;
        logic [63:0]  z;
        logic [63:0]  mag;
        logic [127:0] prod;
        longint       total;
        bit           neg;
        int           sh;
        vmag = (v < 0) ? -v : v;
        sdmag = (std_mirror < 0) ? -longint'(std_mirror) : longint'(std_mirror);
        neg = (v < 0) != (std_mirror < 0);
        z = vmag * mb;
        if (h <= 26) begin
            z = z >> (26 - h);
        end else begin
            sh = h - 26;
            z = (z > (64'hFFFF_FFFF_FFFF_FFFF >> sh)) ? 64'hFFFF_FFFF_FFFF_FFFF : (z << sh);
        end
        prod = {64'd0, z} * {64'd0, sdmag};
        mag = (prod[127:96] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : prod[95:32];
        if (mag > (64'd1 << 40)) mag = 64'd1 << 40;
        total = neg ? -longint'(mag) : longint'(mag);
        total = total + longint'(mean_mirror);
        if (total > 64'sd2147483647) total = 64'sd2147483647;
        if (total < -64'sd2147483648) total = -64'sd2147483648;
        return total[31:0];
    endfunction

    // Returns 0 for a rejected pair, otherwise pushes both expected samples.
    function automatic bit predict_gaussian_pair(logic [31:0] ua, logic [31:0] ub);
        longint       v1, v2;
        logic [63:0]  s, x, y, f, nl, w, r, q, mb, m1, m2;
        logic [127:0] prod;
        int           k, e, h, i;
        gauss_out_t   o;
        v1 = longint'({32'd0, ua}) - 64'sd2147483648;
        v2 = longint'({32'd0, ub}) - 64'sd2147483648;
        m1 = (v1 < 0) ? -v1 : v1;
        m2 = (v2 < 0) ? -v2 : v2;
        s = m1 * m1 + m2 * m2;
        if (s == 0 || s >= (64'd1 << 62)) return 1'b0;
        k = 0;
        while (k < 63 && (s >> (k + 1)) != 0) k++;
        x = (k >= 31) ? (s >> (k - 31)) : (s << (31 - k));
        e = 62 - k;
        f = 0;
        for (i = 0; i < pgg_pkg::CORDIC_STAGES_DEF; i++) begin
            y = (x * x) >> 31;
            f = f << 1;
            if (y >= (64'd1 << 32)) begin
                f = f | 64'd1;
                y = y >> 1;
            end
            x = y;
        end
        x = (k >= 31) ? (s >> (k - 31)) : (s << (31 - k));
        f = f << (pgg_pkg::F_BITS - pgg_pkg::CORDIC_STAGES_DEF);
        nl = (64'(e) << 48) - f;
        prod = {64'd0, nl} * {64'd0, pgg_pkg::LN2_HI, pgg_pkg::LN2_LO};
        w = prod[127:64] << 1;
        if (e % 2 == 1) begin
            w = w << 1;
            e = e - 1;
        end
        h = e / 2;
        r = 64'hFFFF_FFFF_FFFF_FFFF / x;
        prod = {64'd0, w} * {64'd0, r};
        q = prod[90:27];
        mb = isqrt64(q);
        o.sample = scale_sample(v1, mb, h);
        o.last = 1'b0;
        pending_samples.push_back(o);
        o.sample = scale_sample(v2, mb, h);
        o.last = 1'b1;
        pending_samples.push_back(o);
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("MISMATCH %s: expected %h, got %h at %0t", what, want, got, $time);
        errors++;
    endtask

    task automatic write_reg(logic [pgg_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == pgg_pkg::REG_MEAN) mean_mirror = val;
        else if (idx == pgg_pkg::REG_STD_DEV) std_mirror = val;
    endtask

    task automatic send_pair(logic [31:0] ua, logic [31:0] ub, bit known_reject);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(0, 99) < 38) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_uniform_a <= ua;
        s_uniform_b <= ub;
        do @(posedge aclk); while (!s_ready);
        pairs_sent++;
        if (known_reject) pairs_rejected++;
        else if (!predict_gaussian_pair(ua, ub)) pairs_rejected++;
    endtask

    task automatic settle_idle();
        s_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] random_uniform_pair_part(int mode);
        case (mode)
            7: return 32'h8000_0000 + $urandom_range(0, 16'hFFFF) - 32'h8000;
            8: return 32'hFFFF_FFFF - $urandom_range(0, 255);
            9: return 32'h8000_0000 + $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    pair_row_t directed_rows[$] = '{
        '{32'h8000_0000, 32'h8000_0000, 1'b1},
        '{32'h0000_0000, 32'h0000_0000, 1'b1},
        '{32'h0000_0000, 32'h8000_0000, 1'b1},
        '{32'h8000_0000, 32'h0000_0000, 1'b1},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1},
        '{32'hFFFF_FFFF, 32'h8000_0000, 1'b0},
        '{32'h8000_0000, 32'h0000_0001, 1'b0},
        '{32'h8000_0001, 32'h8000_0000, 1'b0},
        '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0},
        '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0},
        '{32'h8000_0001, 32'h8000_0001, 1'b0},
        '{32'hC000_0000, 32'hC000_0000, 1'b0},
        '{32'h4000_0000, 32'hC000_0000, 1'b0},
        '{32'h4000_0000, 32'h4000_0000, 1'b0},
        '{32'hA000_0000, 32'h6000_0000, 1'b0},
        '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0},
        '{32'h0000_0001, 32'h8000_0000, 1'b0},
        '{32'hB504_F334, 32'hB504_F333, 1'b0},
        '{32'hFFFF_FFFE, 32'h8000_0000, 1'b0},
        '{32'h8000_0000, 32'hFFFF_0000, 1'b0}
    };

    logic [31:0] phase_mean[NUM_PHASES] = '{32'h0, 32'h0005_0000, 32'h7FFF_FFFF,
                                            32'h8000_0000, 32'h0, 32'hFFFD_0000};
    logic [31:0] phase_std[NUM_PHASES] = '{32'h0001_0000, 32'h0000_8000, 32'h7FFF_FFFF,
                                           32'h8000_0000, 32'hFFFF_0000, 32'h0};

    initial begin
        int mode;
        logic [31:0] ua, ub;
        errors = 0;
        pairs_sent = 0;
        pairs_rejected = 0;
        calm = 1'b0;
        hold_request = 1'b0;
        mean_mirror = 0;
        std_mirror = 32'h0001_0000;
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= pgg_pkg::REG_MEAN;
        cfg_wdata <= 32'd0;
        s_valid <= 1'b0;
        s_uniform_a <= 32'd0;
        s_uniform_b <= 32'd0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_pair(directed_rows[i].ua, directed_rows[i].ub, directed_rows[i].known_reject);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                settle_idle();
                write_reg(pgg_pkg::REG_MEAN, phase_mean[p]);
                write_reg(pgg_pkg::REG_STD_DEV, phase_std[p]);
                if (p == 4) write_reg(REG_UNUSED, 32'hDEAD_BEEF);
            end
            calm = (p == 1);
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                if (p == 0 && n == 20) hold_request = 1'b1;
                mode = $urandom_range(0, 9);
                ua = random_uniform_pair_part(mode);
                ub = random_uniform_pair_part(mode);
                if (mode == 9) ub = $urandom;
                send_pair(ua, ub, 1'b0);
            end
        end
        calm = 1'b0;
        settle_idle();
        $display("Sent %0d uniform pairs over %0d register settings, %0d of them rejected;",
                 pairs_sent, NUM_PHASES, pairs_rejected);
        $display("checked %0d samples, including saturation and negative scaling.",
                 samples_seen);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        int hold_left;
        gauss_out_t want;
        samples_seen = 0;
        hold_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                samples_seen++;
                if (pending_samples.size() == 0) begin
                    report_mismatch("unexpected sample", 32'd0, m_sample);
                end else begin
                    want = pending_samples.pop_front();
                    if (m_sample !== want.sample)
                        report_mismatch("sample", want.sample, m_sample);
                    if (m_last_of_pair !== want.last)
                        report_mismatch("last_of_pair", {31'd0, want.last},
                                        {31'd0, m_last_of_pair});
                end
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 38);
            end
        end
    end

    initial begin
        stall_count = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall_count = 0;
            else stall_count++;
            if (stall_count >= STALL_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

endmodule

### polar_gaussian_generator_unit.f
+incdir+src
src/pgg_pkg.sv
src/pgg_log_cell.sv
src/pgg_div_cell.sv
src/pgg_sqrt_cell.sv
src/polar_gaussian_generator_unit.sv
tb/tb_polar_gaussian_generator_unit.sv
